// File: design/chained_hash_table_defines.svh
// Assertion macros used by the hash table sequencer.
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, ignored while reset is applied.
`define CHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while reset is applied.
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/cht_pkg.sv
package cht_pkg;

  // Fixed field widths
  localparam int unsigned KEY_W = 8;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CNT_W = 4;

  // Defaults for the top-level parameters
  localparam int unsigned BUCKETS_DEF      = 5;
  localparam int unsigned BUCKET_DEPTH_DEF = 8;

  // Request kind codes
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic                    kind;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } cht_req_t;

  typedef struct packed {
    logic                    found;
    logic signed [VAL_W-1:0] result_value;
    logic                    dropped;
  } cht_rsp_t;

  // One stored entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cht_entry_t;

  // Entry memory port control
  typedef struct packed {
    logic wr;
    logic rd;
  } cht_mem_ctl_t;

endpackage

// File: design/cht_mem.sv
module cht_mem #(
  parameter int unsigned SLOTS  = 40,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                 clk_i,
  input  cht_pkg::cht_mem_ctl_t ctl_i,
  input  logic [ADDR_W-1:0]    addr_i,
  input  cht_pkg::cht_entry_t  wdata_i,
  output cht_pkg::cht_entry_t  rdata_o
);
  import cht_pkg::*;

  cht_entry_t mem [SLOTS];
  cht_entry_t rdata_q;

  // Single port: write or registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/cht_seq.sv
`include "chained_hash_table_defines.svh"

module cht_seq #(
  parameter int unsigned BUCKETS      = 5,
  parameter int unsigned BUCKET_DEPTH = 8,
  parameter int unsigned ADDR_W       = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  cht_pkg::cht_req_t     req_i,
  output logic                  done_o,
  output cht_pkg::cht_rsp_t     rsp_o,
  output cht_pkg::cht_mem_ctl_t mem_ctl_o,
  output logic [ADDR_W-1:0]     mem_addr_o,
  output cht_pkg::cht_entry_t   mem_wdata_o,
  input  cht_pkg::cht_entry_t   mem_rdata_i
);
  import cht_pkg::*;

  localparam int unsigned BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUCKET_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_SCAN
  } state_e;

  state_e             state_q;
  logic               kind_q;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   value_q;
  logic [BKT_W-1:0]   bucket_q;
  logic [ADDR_W-1:0]  base_q;
  logic [CNT_W-1:0]   scan_q;
  logic               pend_q;
  logic               done_q;
  cht_rsp_t           rsp_q;
  logic [CNT_W-1:0]   cnt_q [BUCKETS];

  logic [BKT_W-1:0]   bkt_lut [256];
  logic [CNT_W-1:0]   cnt_cur;
  logic [CNT_W-1:0]   fill;
  logic [ADDR_W-1:0]  base_now;
  logic [CNT_W-1:0]   scan_dec;
  logic               hit;
  logic               full;
  logic               accept;

  // Bucket of every key, worked out at elaboration
  for (genvar g = 0; g < 256; g++) begin : g_lut
    assign bkt_lut[g] = BKT_W'(g % BUCKETS);
  end

  // Fill of the current bucket, its base slot, the key compare and request accept
  always_comb begin
    cnt_cur  = cnt_q[bucket_q];
    fill     = (cnt_cur > DEPTH_C) ? DEPTH_C : cnt_cur;
    full     = (fill >= DEPTH_C);
    base_now = ADDR_W'(int'(bucket_q) * BUCKET_DEPTH);
    scan_dec = scan_q - 1'b1;
    hit      = pend_q && (mem_rdata_i.key == key_q);
    accept   = start && !busy;
  end

  // Entry memory port: insert write in setup, one read per scan step
  always_comb begin
    mem_ctl_o.wr      = (state_q == S_SETUP) && (kind_q == KIND_INSERT) && !full;
    mem_ctl_o.rd      = (state_q == S_SCAN) && !hit && (scan_q != '0);
    mem_addr_o        = (state_q == S_SETUP) ? base_now + ADDR_W'(fill)
                                             : base_q + ADDR_W'(scan_dec);
    mem_wdata_o.key   = key_q;
    mem_wdata_o.value = value_q;
  end

  // Sequencer, bucket counts and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      kind_q   <= KIND_INSERT;
      key_q    <= '0;
      value_q  <= '0;
      bucket_q <= '0;
      base_q   <= '0;
      scan_q   <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      rsp_q    <= '0;
      for (int i = 0; i < BUCKETS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            kind_q   <= req_i.kind;
            key_q    <= req_i.key;
            value_q  <= req_i.value;
            bucket_q <= bkt_lut[req_i.key];
            state_q  <= S_SETUP;
          end
        end
        S_SETUP: begin
          base_q <= base_now;
          scan_q <= fill;
          pend_q <= 1'b0;
          if (kind_q == KIND_INSERT) begin
            if (!full) begin
              cnt_q[bucket_q] <= fill + 1'b1;
            end
            rsp_q.found        <= 1'b0;
            rsp_q.result_value <= '0;
            rsp_q.dropped      <= full;
            done_q             <= 1'b1;
            state_q            <= S_IDLE;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          priority if (hit) begin
            rsp_q.found        <= 1'b1;
            rsp_q.result_value <= mem_rdata_i.value;
            rsp_q.dropped      <= 1'b0;
            done_q             <= 1'b1;
            pend_q             <= 1'b0;
            state_q            <= S_IDLE;
          end else if (scan_q == '0) begin
            rsp_q              <= '0;
            done_q             <= 1'b1;
            pend_q             <= 1'b0;
            state_q            <= S_IDLE;
          end else begin
            scan_q <= scan_dec;
            pend_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Checks
  `CHT_ASSERT_NOW(a_done_idle, clk_i, rst_ni, done_q, state_q == S_IDLE)
  `CHT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy && !done_q)
  `CHT_ASSERT_NOW(a_wr_insert, clk_i, rst_ni, mem_ctl_o.wr, kind_q == KIND_INSERT && !mem_ctl_o.rd)
  `CHT_ASSERT_NOW(a_found_search, clk_i, rst_ni, done_q && rsp_q.found, kind_q == KIND_SEARCH && !rsp_q.dropped)
  `CHT_ASSERT_NOW(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q[bucket_q] <= DEPTH_C)

endmodule

// File: design/chained_hash_table.sv
// Channel   Ports                     Direction  Transfer
// request   start, busy, req_i        in         start high while busy low
// result    done_o, rsp_o             out        done_o high for one cycle
//
// An insert keeps busy high for 1 cycle; the result strobes in the cycle after.
// A search keeps busy high until the scan of its bucket ends: the single entry
// memory port reads one slot of the bucket per cycle, newest first, and the
// shared key compare checks it in the cycle after; a hit ends the scan early.
// rst_ni clears the bucket fill counts at once; entries need no clearing.
// The receiver cannot stall: each result is valid only while done_o is high.
module chained_hash_table #(
  parameter int unsigned BUCKETS      = cht_pkg::BUCKETS_DEF,
  parameter int unsigned BUCKET_DEPTH = cht_pkg::BUCKET_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cht_pkg::cht_req_t req_i,
  output logic              done_o,
  output cht_pkg::cht_rsp_t rsp_o
);
  import cht_pkg::*;

  localparam int unsigned SLOTS  = BUCKETS * BUCKET_DEPTH;
  localparam int unsigned ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cht_mem_ctl_t      mem_ctl;
  logic [ADDR_W-1:0] mem_addr;
  cht_entry_t        mem_wdata;
  cht_entry_t        mem_rdata;

  // Sequencer with bucket counts and key compare
  cht_seq #(
    .BUCKETS      (BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .ADDR_W       (ADDR_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .mem_ctl_o   (mem_ctl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  // Key/value entry store
  cht_mem #(
    .SLOTS  (SLOTS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

// File: dv/cht_tb_pkg.sv
`timescale 1ns / 1ps

package cht_tb_pkg;
  import cht_pkg::*;

  localparam int unsigned NUM_BUCKETS = BUCKETS_DEF;
  localparam int unsigned CHAIN_DEPTH = BUCKET_DEPTH_DEF;
  localparam int unsigned NUM_SLOTS   = NUM_BUCKETS * CHAIN_DEPTH;

  // Tracks table contents, predicts each answer and checks what comes back
  class hash_table_scoreboard;
    logic [KEY_W-1:0] chain_keys [NUM_SLOTS];
    logic [VAL_W-1:0] chain_vals [NUM_SLOTS];
    int unsigned      chain_fill [NUM_BUCKETS];
    cht_rsp_t         pending_answers[$];
    int unsigned      mismatches;
    int unsigned      inserts;
    int unsigned      refused;
    int unsigned      searches;
    int unsigned      hits;

    function new();
      foreach (chain_fill[i]) chain_fill[i] = 0;
      foreach (chain_keys[i]) chain_keys[i] = '0;
      foreach (chain_vals[i]) chain_vals[i] = '0;
      mismatches = 0;
      inserts    = 0;
      refused    = 0;
      searches   = 0;
      hits       = 0;
    endfunction

    // Apply one request to the shadow table and return the expected answer
    function cht_rsp_t predict_answer(cht_req_t r);
      cht_rsp_t    a;
      int unsigned b;
      int unsigned n;
      int unsigned base;
      a    = '0;
      b    = r.key % NUM_BUCKETS;
      n    = chain_fill[b];
      base = b * CHAIN_DEPTH;
      if (r.kind == KIND_INSERT) begin
        if (n >= CHAIN_DEPTH) begin
          a.dropped = 1'b1;
        end else begin
          chain_keys[base + n] = r.key;
          chain_vals[base + n] = r.value;
          chain_fill[b]        = n + 1;
        end
      end else begin
        // newest entry first; first key match wins
        for (int s = int'(n) - 1; s >= 0; s--) begin
          if (chain_keys[base + s] == r.key) begin
            a.found        = 1'b1;
            a.result_value = chain_vals[base + s];
            break;
          end
        end
      end
      return a;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task note_request(cht_req_t r);
      cht_rsp_t a;
      a = predict_answer(r);
      pending_answers.push_back(a);
      if (r.kind == KIND_INSERT) begin
        inserts++;
        if (a.dropped) refused++;
      end else begin
        searches++;
        if (a.found) hits++;
      end
    endtask

    task check_result(cht_rsp_t got);
      cht_rsp_t want;
      if (pending_answers.size() == 0) begin
        report("result strobe with no request outstanding");
      end else begin
        want = pending_answers.pop_front();
        if (got.found !== want.found)
          report($sformatf("found: got %b, want %b", got.found, want.found));
        if (got.result_value !== want.result_value)
          report($sformatf("result_value: got %h, want %h",
                           got.result_value, want.result_value));
        if (got.dropped !== want.dropped)
          report($sformatf("dropped: got %b, want %b", got.dropped, want.dropped));
      end
    endtask
  endclass

endpackage

// File: dv/chained_hash_table_tb.sv
`timescale 1ns / 1ps

module chained_hash_table_tb;
  import cht_pkg::*;
  import cht_tb_pkg::*;

  localparam int unsigned RANDOM_REQS = 1530;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  cht_req_t req;
  logic     done_o;
  cht_rsp_t rsp_o;

  hash_table_scoreboard   tally;
  int unsigned            burst_left;
  int unsigned            cycle_count;
  logic [KEY_W-1:0]       inserted_keys[$];

  chained_hash_table u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run-length guard
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("chained_hash_table regression: fail");
      $finish;
    end
  end

  // Result monitor: each strobe is checked against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) tally.check_result(rsp_o);
  end

  // Send one request; idle gaps are inserted between bursts
  task automatic issue(input cht_req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      start <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 14) : $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
      // mostly short bursts, sometimes long stretches with no idling
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 6);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy);
    tally.note_request(r);
    if (r.kind == KIND_INSERT) inserted_keys.push_back(r.key);
    burst_left--;
  endtask

  task automatic issue_fields(input logic kind, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    cht_req_t r;
    r.kind  = kind;
    r.key   = key;
    r.value = value;
    issue(r);
  endtask

  initial begin
    cht_req_t    r;
    int unsigned ins_pct;
    tally      = new();
    burst_left = 0;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty miss, value extremes, duplicates, full bucket, deep scans
    issue_fields(KIND_SEARCH, 8'd0,   32'h0000_0000);
    issue_fields(KIND_INSERT, 8'd0,   32'h8000_0000);
    issue_fields(KIND_INSERT, 8'd255, 32'h7fff_ffff);
    issue_fields(KIND_SEARCH, 8'd255, 32'h0000_0000);
    issue_fields(KIND_SEARCH, 8'd0,   32'hffff_ffff);
    issue_fields(KIND_INSERT, 8'd0,   32'hffff_ffff);  // duplicate key
    issue_fields(KIND_SEARCH, 8'd0,   32'h0000_0000);  // newest copy wins
    issue_fields(KIND_SEARCH, 8'd10,  32'h0000_0000);  // miss in non-empty bucket
    issue_fields(KIND_INSERT, 8'd5,   32'h0000_0005);
    issue_fields(KIND_INSERT, 8'd10,  32'h0000_000a);
    issue_fields(KIND_INSERT, 8'd15,  32'h5555_5555);
    issue_fields(KIND_INSERT, 8'd20,  32'haaaa_aaaa);
    issue_fields(KIND_INSERT, 8'd25,  32'h0000_0001);  // bucket now full
    issue_fields(KIND_INSERT, 8'd30,  32'h1234_5678);  // refused
    issue_fields(KIND_SEARCH, 8'd30,  32'h0000_0000);  // refused key is absent
    issue_fields(KIND_SEARCH, 8'd255, 32'h0000_0000);  // near the oldest slot
    issue_fields(KIND_SEARCH, 8'd25,  32'h0000_0000);  // newest slot
    issue_fields(KIND_SEARCH, 8'd100, 32'h0000_0000);  // full-depth miss
    issue_fields(KIND_INSERT, 8'd1,   32'h0000_0000);
    issue_fields(KIND_SEARCH, 8'd1,   32'hffff_ffff);  // hit whose value is zero
    issue_fields(KIND_SEARCH, 8'd254, 32'hffff_ffff);  // empty bucket

    // Random: insert-heavy while the table fills, then mostly lookups
    for (int i = 0; i < RANDOM_REQS; i++) begin
      ins_pct = (i < 80) ? 70 : 20;
      r.value = $urandom;
      if ($urandom_range(0, 99) < ins_pct) begin
        r.kind = KIND_INSERT;
        r.key  = KEY_W'($urandom_range(0, 255));
      end else begin
        r.kind = KIND_SEARCH;
        if (inserted_keys.size() > 0 && $urandom_range(0, 99) < 60)
          r.key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        else
          r.key = KEY_W'($urandom_range(0, 255));
      end
      issue(r);
    end
    start <= 1'b0;

    // Drain, then watch a little longer for stray strobes
    while (tally.pending_answers.size() > 0) @(posedge clk_i);
    repeat (CHAIN_DEPTH + 8) @(posedge clk_i);

    $display("covered %0d inserts (%0d refused on a full bucket), %0d searches (%0d hits)",
             tally.inserts, tally.refused, tally.searches, tally.hits);
    $display("%0d mismatches over %0d cycles", tally.mismatches, cycle_count);
    if (tally.mismatches == 0) begin
      $display("chained_hash_table regression: pass");
    end else begin
      $display("chained_hash_table regression: fail");
    end
    $finish;
  end

endmodule

// File: chained_hash_table.f
+incdir+design
design/cht_pkg.sv
design/cht_mem.sv
design/cht_seq.sv
design/chained_hash_table.sv
dv/cht_tb_pkg.sv
dv/chained_hash_table_tb.sv
